>>> design/gftg_pkg.sv
// ----------------------------------------------------------------------------
// gftg_pkg
// Shared types and constants for the trilinear field gather block.
// ----------------------------------------------------------------------------
package gftg_pkg;

	localparam int MAX_NODES = 32;
	localparam int IDX_W     = $clog2(MAX_NODES);
	localparam int ADDR_W    = 3 * IDX_W;
	localparam int FIELD_W   = 32;
	localparam int POS_W     = 32;
	localparam int INV_W     = 32;
	localparam int CNT_W     = 6;
	localparam int WT_W      = 17;
	localparam int PADDR_W   = 5;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// register byte addresses
	localparam logic [PADDR_W-1:0] REG_INV_X   = 5'd0;
	localparam logic [PADDR_W-1:0] REG_INV_Y   = 5'd4;
	localparam logic [PADDR_W-1:0] REG_INV_Z   = 5'd8;
	localparam logic [PADDR_W-1:0] REG_NODES_X = 5'd12;
	localparam logic [PADDR_W-1:0] REG_NODES_Y = 5'd16;
	localparam logic [PADDR_W-1:0] REG_NODES_Z = 5'd20;

	localparam logic [INV_W-1:0] INV_RESET   = 32'h0100_0000;
	localparam logic [CNT_W-1:0] NODES_RESET = 6'd32;

	// controller to datapath
	typedef struct packed {
		logic       write_node;  // store the input node vector
		logic       load_axis;   // register position times reciprocal
		logic       axis_calc;   // derive node index and weight
		logic       rd_en;       // read one corner
		logic [2:0] corner;      // corner being read
		logic       acc_en;      // capture corner read data
		logic [2:0] acc_corner;  // corner whose read data is captured
		logic       blend_en;    // run blend tree step
		logic [2:0] blend_step;
		logic       out_load;    // load the output register
	} gftg_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic bad;
	} gftg_stat_t;

endpackage

>>> design/gftg_if.sv
// ----------------------------------------------------------------------------
// gftg_in_if / gftg_out_if
// Valid/ready channels for query and write items and for result items.
// ----------------------------------------------------------------------------
interface gftg_in_if;
	import gftg_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      opcode;
	logic [IDX_W-1:0]          node_i;
	logic [IDX_W-1:0]          node_j;
	logic [IDX_W-1:0]          node_k;
	logic signed [FIELD_W-1:0] node_fx;
	logic signed [FIELD_W-1:0] node_fy;
	logic signed [FIELD_W-1:0] node_fz;
	logic signed [POS_W-1:0]   pos_x;
	logic signed [POS_W-1:0]   pos_y;
	logic signed [POS_W-1:0]   pos_z;
	modport source (output valid, opcode, node_i, node_j, node_k, node_fx, node_fy, node_fz,
		pos_x, pos_y, pos_z, input ready);
	modport sink (input valid, opcode, node_i, node_j, node_k, node_fx, node_fy, node_fz,
		pos_x, pos_y, pos_z, output ready);
endinterface

interface gftg_out_if;
	import gftg_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [FIELD_W-1:0] field_x;
	logic signed [FIELD_W-1:0] field_y;
	logic signed [FIELD_W-1:0] field_z;
	logic                      out_of_grid;
	modport source (output valid, field_x, field_y, field_z, out_of_grid, input ready);
	modport sink (input valid, field_x, field_y, field_z, out_of_grid, output ready);
endinterface

>>> design/grid_field_trilinear_gather.sv
// ----------------------------------------------------------------------------
// grid_field_trilinear_gather
// Trilinear interpolation of a stored 3D vector field.
// ----------------------------------------------------------------------------
// Usage:
//  in channel: opcode 0 writes one node vector (no result), opcode 1 queries
//  the field at a Q16.16 position and yields exactly one result transaction.
//  out channel: interpolated field plus out_of_grid flag (fields zero then).
//  APB port: reciprocal cell sizes and node counts, written while idle.
// Sequence:
//  a write is stored as it is accepted; a query goes through the axis product,
//  index check, eight corner reads from one read port of the node memory,
//  a capture step and four blend steps, or straight to the result when out
//  of grid. No new item is taken until the query's result is loaded.
// Reset:
//  clears configuration to defaults and control state; node memory contents
//  are undefined until written.
// Stall:
//  a finished result sits in the output register; the sequencer holds before
//  loading the next result until the receiver takes it.
// ----------------------------------------------------------------------------
module grid_field_trilinear_gather
	import gftg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	gftg_in_if.sink            in_ch,
	gftg_out_if.source         out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	gftg_cmd_t          cmd;
	gftg_stat_t         stat;
	logic [FIELD_W-1:0] res_x, res_y, res_z;
	logic               res_bad;
	logic               ovalid_q;
	logic               out_busy;

	assign pready   = 1'b1;
	assign out_busy = ovalid_q && !out_ch.ready;

	gftg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_opcode (in_ch.opcode),
		.in_ready  (in_ch.ready),
		.out_busy  (out_busy),
		.stat      (stat),
		.cmd       (cmd)
	);

	gftg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.node_i    (in_ch.node_i),
		.node_j    (in_ch.node_j),
		.node_k    (in_ch.node_k),
		.node_fx   (in_ch.node_fx),
		.node_fy   (in_ch.node_fy),
		.node_fz   (in_ch.node_fz),
		.pos_x     (in_ch.pos_x),
		.pos_y     (in_ch.pos_y),
		.pos_z     (in_ch.pos_z),
		.cfg_we    (psel && penable && pwrite),
		.cfg_addr  (paddr),
		.cfg_wdata (pwdata),
		.cfg_rdata (prdata),
		.res_x     (res_x),
		.res_y     (res_y),
		.res_z     (res_z),
		.res_bad   (res_bad)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			ovalid_q <= 1'b1;
		end else if (out_ch.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_ch.field_x     <= res_x;
			out_ch.field_y     <= res_y;
			out_ch.field_z     <= res_z;
			out_ch.out_of_grid <= res_bad;
		end
	end

	assign out_ch.valid = ovalid_q;

	// a result is never loaded over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(ovalid_q && !out_ch.ready))
		else $error("result overwritten");

	// a query accept is followed by the axis step
	a_query_axis: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_axis |=> cmd.axis_calc)
		else $error("axis step missing");

	// no new item while a corner read runs
	a_no_accept_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> !in_ch.ready)
		else $error("accept during read");

endmodule

>>> design/gftg_ctrl.sv
// ----------------------------------------------------------------------------
// gftg_ctrl
// Sequencer: accepts an item; an in-range query goes through axis math, eight
// corner reads and the blend tree, then hands the result to the output.
// ----------------------------------------------------------------------------
module gftg_ctrl
	import gftg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_opcode,
	output logic       in_ready,
	input  logic       out_busy,
	input  gftg_stat_t stat,
	output gftg_cmd_t  cmd
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_AXIS  = 7'b0000010,
		ST_CHECK = 7'b0000100,
		ST_READ  = 7'b0001000,
		ST_BLEND = 7'b0010000,
		ST_OUT   = 7'b0100000,
		ST_WAIT  = 7'b1000000
	} state_t;

	state_t     state_q;
	logic [2:0] cnt_q;
	logic       last_rd_q;
	logic       take;

	assign in_ready = (state_q == ST_IDLE);
	assign take     = in_valid && in_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			last_rd_q <= 1'b0;
		end else begin
			last_rd_q <= (state_q == ST_READ) && (cnt_q == 3'd7);
			unique case (state_q)
				ST_IDLE: begin
					if (take && in_opcode == OP_QUERY) state_q <= ST_AXIS;
				end
				ST_AXIS: state_q <= ST_CHECK;
				ST_CHECK: begin
					cnt_q <= '0;
					if (stat.bad) state_q <= ST_OUT;
					else state_q <= ST_READ;
				end
				ST_READ: begin
					if (cnt_q == 3'd7) begin
						state_q <= ST_BLEND;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				ST_BLEND: begin
					// first blend cycle only captures the last corner
					if (!last_rd_q) cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd3) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_busy) state_q <= ST_IDLE;
					else state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (!out_busy) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	logic [2:0] rd_q;
	logic       acc_q;
	// read data arrives in the cycle after the address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			acc_q <= 1'b0;
		end else begin
			rd_q  <= cnt_q;
			acc_q <= (state_q == ST_READ);
		end
	end

	// command decode
	always_comb begin
		cmd            = '0;
		cmd.write_node = take && in_opcode == OP_WRITE;
		cmd.load_axis  = take && in_opcode == OP_QUERY;
		cmd.axis_calc  = (state_q == ST_AXIS);
		cmd.rd_en      = (state_q == ST_READ);
		cmd.corner     = cnt_q;
		cmd.acc_en     = acc_q;
		cmd.acc_corner = rd_q;
		cmd.blend_en   = (state_q == ST_BLEND) && !last_rd_q;
		cmd.blend_step = cnt_q;
		cmd.out_load   = ((state_q == ST_OUT) || (state_q == ST_WAIT)) && !out_busy;
	end

endmodule

>>> design/gftg_dp.sv
// ----------------------------------------------------------------------------
// gftg_dp
// Datapath: configuration registers, node memories, per-axis index and weight,
// corner capture and a blend unit stepped by the controller.
// ----------------------------------------------------------------------------
module gftg_dp
	import gftg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  gftg_cmd_t           cmd,
	output gftg_stat_t          stat,
	input  logic [IDX_W-1:0]    node_i,
	input  logic [IDX_W-1:0]    node_j,
	input  logic [IDX_W-1:0]    node_k,
	input  logic [FIELD_W-1:0]  node_fx,
	input  logic [FIELD_W-1:0]  node_fy,
	input  logic [FIELD_W-1:0]  node_fz,
	input  logic [POS_W-1:0]    pos_x,
	input  logic [POS_W-1:0]    pos_y,
	input  logic [POS_W-1:0]    pos_z,
	input  logic                cfg_we,
	input  logic [PADDR_W-1:0]  cfg_addr,
	input  logic [31:0]         cfg_wdata,
	output logic [31:0]         cfg_rdata,
	output logic [FIELD_W-1:0]  res_x,
	output logic [FIELD_W-1:0]  res_y,
	output logic [FIELD_W-1:0]  res_z,
	output logic                res_bad
);

	localparam int U_W = POS_W + INV_W + 1;

	logic [INV_W-1:0] inv_q [3];
	logic [CNT_W-1:0] nodes_q [3];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				inv_q[a]   <= INV_RESET;
				nodes_q[a] <= NODES_RESET;
			end
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_INV_X:   inv_q[0]   <= cfg_wdata;
				REG_INV_Y:   inv_q[1]   <= cfg_wdata;
				REG_INV_Z:   inv_q[2]   <= cfg_wdata;
				REG_NODES_X: nodes_q[0] <= cfg_wdata[CNT_W-1:0];
				REG_NODES_Y: nodes_q[1] <= cfg_wdata[CNT_W-1:0];
				REG_NODES_Z: nodes_q[2] <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// register read mux
	always_comb begin
		unique case (cfg_addr)
			REG_INV_X:   cfg_rdata = inv_q[0];
			REG_INV_Y:   cfg_rdata = inv_q[1];
			REG_INV_Z:   cfg_rdata = inv_q[2];
			REG_NODES_X: cfg_rdata = {26'd0, nodes_q[0]};
			REG_NODES_Y: cfg_rdata = {26'd0, nodes_q[1]};
			REG_NODES_Z: cfg_rdata = {26'd0, nodes_q[2]};
			default:     cfg_rdata = '0;
		endcase
	end

	// position times reciprocal, one 32x33 product per axis
	logic signed [U_W-1:0] u_q [3];
	logic [POS_W-1:0] pos_in [3];
	assign pos_in[0] = pos_x;
	assign pos_in[1] = pos_y;
	assign pos_in[2] = pos_z;

	always_ff @(posedge clk) begin
		if (cmd.load_axis) begin
			for (int a = 0; a < 3; a++)
				u_q[a] <= U_W'($signed(pos_in[a]) * $signed({1'b0, inv_q[a]}));
		end
	end

	// ceiling node, weight and range check
	logic [IDX_W-1:0] c_q [3];
	logic [WT_W-1:0]  w_q [3];
	logic             bad_q;
	always_ff @(posedge clk) begin
		if (cmd.axis_calc) begin
			logic bad;
			bad = 1'b0;
			for (int a = 0; a < 3; a++) begin
				logic [39:0]          frac;
				logic [40:0]          w40;
				logic signed [U_W-41:0] ip;
				logic signed [U_W-40:0] cn;
				logic [CNT_W-1:0]     n;
				frac = u_q[a][39:0];
				ip   = u_q[a][U_W-1:40];
				w40  = (frac == '0) ? 41'h100_0000_0000 : {1'b0, frac};
				cn   = (frac == '0) ? {ip[U_W-41], ip} : ({ip[U_W-41], ip} + (U_W-39)'(1));
				n    = (nodes_q[a] > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : nodes_q[a];
				if (cn < 1 || cn > $signed({1'b0, n}) - 1) bad = 1'b1;
				c_q[a] <= cn[IDX_W-1:0];
				w_q[a] <= WT_W'((w40 + 41'd8388608) >> 24);
			end
			bad_q <= bad;
		end
	end
	assign stat.bad = bad_q;

	// node memories
	logic [FIELD_W-1:0] mem_x [2**ADDR_W];
	logic [FIELD_W-1:0] mem_y [2**ADDR_W];
	logic [FIELD_W-1:0] mem_z [2**ADDR_W];
	logic [FIELD_W-1:0] rdx, rdy, rdz;
	logic [ADDR_W-1:0]  waddr, raddr;
	logic [IDX_W-1:0]   ci, cj, ck;

	assign waddr = {node_i, node_j, node_k};
	assign ci    = c_q[0] - IDX_W'(!cmd.corner[0]);
	assign cj    = c_q[1] - IDX_W'(!cmd.corner[1]);
	assign ck    = c_q[2] - IDX_W'(!cmd.corner[2]);
	assign raddr = {ci, cj, ck};

	always_ff @(posedge clk) begin
		if (cmd.write_node) begin
			mem_x[waddr] <= node_fx;
			mem_y[waddr] <= node_fy;
			mem_z[waddr] <= node_fz;
		end
		if (cmd.rd_en) begin
			rdx <= mem_x[raddr];
			rdy <= mem_y[raddr];
			rdz <= mem_z[raddr];
		end
	end

	// corner capture, 3 components by 8 corners
	logic signed [FIELD_W+1:0] cor_q [3][8];
	always_ff @(posedge clk) begin
		if (cmd.acc_en) begin
			cor_q[0][cmd.acc_corner] <= (FIELD_W+2)'($signed(rdx));
			cor_q[1][cmd.acc_corner] <= (FIELD_W+2)'($signed(rdy));
			cor_q[2][cmd.acc_corner] <= (FIELD_W+2)'($signed(rdz));
		end
	end

	// blend unit: a*(1-w) + b*w, rounded half up, per component
	function automatic logic signed [FIELD_W+1:0] blend(
		input logic signed [FIELD_W+1:0] lo,
		input logic signed [FIELD_W+1:0] hi,
		input logic [WT_W-1:0]           w
	);
		logic signed [FIELD_W+WT_W+3:0] acc;
		acc = lo * $signed({1'b0, 17'd65536 - w}) + hi * $signed({1'b0, w}) + 32768;
		return acc[FIELD_W+17:16];
	endfunction

	// blend steps: 0,1 x pairs; 2 y pairs; 3 z pair
	logic signed [FIELD_W+1:0] xb_q [3][4];
	logic signed [FIELD_W+1:0] yb_q [3][2];
	logic signed [FIELD_W+1:0] zb_q [3];
	always_ff @(posedge clk) begin
		if (cmd.blend_en) begin
			for (int f = 0; f < 3; f++) begin
				case (cmd.blend_step)
					3'd0: begin
						xb_q[f][0] <= blend(cor_q[f][0], cor_q[f][1], w_q[0]);
						xb_q[f][1] <= blend(cor_q[f][2], cor_q[f][3], w_q[0]);
					end
					3'd1: begin
						xb_q[f][2] <= blend(cor_q[f][4], cor_q[f][5], w_q[0]);
						xb_q[f][3] <= blend(cor_q[f][6], cor_q[f][7], w_q[0]);
					end
					3'd2: begin
						yb_q[f][0] <= blend(xb_q[f][0], xb_q[f][1], w_q[1]);
						yb_q[f][1] <= blend(xb_q[f][2], xb_q[f][3], w_q[1]);
					end
					default: zb_q[f] <= blend(yb_q[f][0], yb_q[f][1], w_q[2]);
				endcase
			end
		end
	end

	// saturation to field width, zero when out of grid
	function automatic logic [FIELD_W-1:0] sat(input logic signed [FIELD_W+1:0] v);
		if (v > $signed({3'b000, {(FIELD_W-1){1'b1}}})) return {1'b0, {(FIELD_W-1){1'b1}}};
		if (v < $signed({3'b111, {(FIELD_W-1){1'b0}}})) return {1'b1, {(FIELD_W-1){1'b0}}};
		return v[FIELD_W-1:0];
	endfunction

	assign res_bad = bad_q;
	assign res_x   = bad_q ? '0 : sat(zb_q[0]);
	assign res_y   = bad_q ? '0 : sat(zb_q[1]);
	assign res_z   = bad_q ? '0 : sat(zb_q[2]);

endmodule
